### rtl/edge_valued_bdd_node_store_core_macros.svh
`ifndef EDGE_VALUED_BDD_NODE_STORE_CORE_MACROS_SVH
`define EDGE_VALUED_BDD_NODE_STORE_CORE_MACROS_SVH

// Same-cycle implication, gated by reset.
`define EVB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, gated by reset.
`define EVB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/evbdd_pkg.sv
package evbdd_pkg;

  localparam int NODE_COUNT_DEF = 1024;
  localparam int MAX_LEVELS_DEF = 32;

  localparam int LVW = 6;
  localparam int CHW = 10;
  localparam int EVW = 3;
  localparam int TCW = 5;
  localparam int VBW = 33;
  localparam int RVW = 8;

  localparam logic [31:0] HASH_SEED = 32'h0048_0bdd;
  localparam logic [5:0]  HASH_MUL  = 6'd37;
  localparam logic [2:0]  MODULUS   = 3'd5;
  localparam logic [31:0] BYTE_MASK = 32'h0000_00ff;

  localparam logic [TCW-1:0] TERM_RESET = 5'd2;
  localparam logic [TCW-1:0] TERM_MIN   = 5'd1;
  localparam logic [TCW-1:0] TERM_MAX   = 5'd16;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_EVAL   = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ROOT  = 3'd1,
    ST_FULL      = 3'd2,
    ST_ZERO_LVL  = 3'd3,
    ST_WALK_LONG = 3'd4
  } status_t;

  // One node tuple; also the key of the unique table.
  typedef struct packed {
    logic [LVW-1:0] lv;
    logic [CHW-1:0] c0;
    logic [CHW-1:0] c1;
    logic [EVW-1:0] e0;
    logic [EVW-1:0] e1;
  } node_t;

  // Edge value 0..7 reduced mod 5.
  function automatic logic [EVW-1:0] edge_mod5(input logic [EVW-1:0] e);
    edge_mod5 = (e >= MODULUS) ? e - MODULUS : e;
  endfunction

  // x mod 5 for x < 512, by reciprocal multiply.
  function automatic logic [2:0] mod5(input logic [8:0] x);
    logic [17:0] p;
    logic [7:0]  q;
    logic [10:0] qm;
    p  = 18'(x) * 18'd205;
    q  = p[17:10];
    qm = 11'(q) * 11'(MODULUS);
    mod5 = 3'(11'(x) - qm);
  endfunction

endpackage

### rtl/evbdd_ram.sv
module evbdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/evbdd_hash.sv
module evbdd_hash
  import evbdd_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  node_t                         tup,
  output logic                          done,
  output logic [$clog2(NODE_COUNT)-1:0] bucket
);

  localparam int HW = $clog2(NODE_COUNT);
  localparam int MIX_STEPS = 25;

  logic          busy_r, busy_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [31:0]   h_r, h_nxt;
  logic          done_r, done_nxt;

  logic [4:0]  km1;
  logic [31:0] word;
  logic [7:0]  bsel;

  // Byte stream: level, then four bytes (MSB first) of c0, c1, e0, e1, 0, 0.
  always_comb begin
    km1  = 5'(cnt_r - 6'd1);
    word = '0;
    unique case (km1[4:2])
      3'd0:    word = 32'(tup.c0);
      3'd1:    word = 32'(tup.c1);
      3'd2:    word = 32'(tup.e0);
      3'd3:    word = 32'(tup.e1);
      default: word = '0;
    endcase
    if (cnt_r == 6'd0) begin
      bsel = 8'(tup.lv);
    end else begin
      bsel = 8'((word >> {~km1[1:0], 3'b000}) & BYTE_MASK);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    h_nxt    = h_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      h_nxt    = HASH_SEED;
    end else if (busy_r) begin
      h_nxt   = (h_r * 32'(HASH_MUL)) ^ 32'(bsel);
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(MIX_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    h_r   <= h_nxt;
  end

  assign done   = done_r;
  // NODE_COUNT must be a power of two, which the block does not check; the remainder is then the low hash bits.
  assign bucket = h_r[HW-1:0];

endmodule

### rtl/edge_valued_bdd_node_store_core.sv
// Insert: from accept to result, hash start, 25 mix steps and head read,
//   then one node memory read per chain entry compared.
// Evaluate: one node memory read per level walked; a bad root, or an insert at level zero, goes straight to the result.
// One item at a time; the result register lets the next item in while it waits.
// Reset (and any terminal_count write) runs a clear pass over all NODE_COUNT bucket
//   heads, with in_ready low; terminal_count resets to 2.
module edge_valued_bdd_node_store_core
  import evbdd_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [TCW-1:0] cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_func,
  input  logic [LVW-1:0] in_node_level,
  input  logic [CHW-1:0] in_low_child,
  input  logic [CHW-1:0] in_high_child,
  input  logic [EVW-1:0] in_low_edge_value,
  input  logic [EVW-1:0] in_high_edge_value,
  input  logic [CHW-1:0] in_root_handle,
  input  logic [VBW-1:0] in_var_bits,
  input  logic [RVW-1:0] in_root_value,
  input  logic           in_invert_decisions,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_status,
  output logic [CHW-1:0] out_result_handle,
  output logic [2:0]     out_result_value,
  output logic           out_reached_zero
);

  localparam int HW  = $clog2(NODE_COUNT);
  localparam int NFW = HW + 1;                       // next-free handle, can equal NODE_COUNT
  localparam int XW  = (NFW > CHW) ? NFW : CHW;      // width for handle compares
  localparam int SW  = $clog2(MAX_LEVELS + 1);
  localparam int NW  = $bits(node_t) + HW;           // node word: link above tuple

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HRD, S_HDAT, S_NRD, S_NCMP, S_INS, S_ERD, S_ECHK, S_OUT
  } state_t;

  state_t         state_r, state_nxt;
  logic [TCW-1:0] tc_r, tc_nxt;
  logic [NFW-1:0] nfree_r, nfree_nxt;
  logic [HW-1:0]  clr_cnt_r, clr_cnt_nxt;

  // item context
  node_t          tup_r, tup_nxt;
  logic [HW-1:0]  bkt_r, bkt_nxt;
  logic [HW-1:0]  head_r, head_nxt;
  logic [XW-1:0]  cur_r, cur_nxt;          // walk position
  logic [VBW-1:0] var_r, var_nxt;
  logic [RVW-1:0] rootv_r, rootv_nxt;
  logic           inv_r, inv_nxt;
  logic [2:0]     sum_r, sum_nxt;
  logic [SW-1:0]  steps_r, steps_nxt;

  // pending result
  status_t        rs_r, rs_nxt;
  logic [CHW-1:0] rh_r, rh_nxt;
  logic [2:0]     rv_r, rv_nxt;
  logic           rz_r, rz_nxt;

  // result register
  logic           ov_r, ov_nxt;
  status_t        os_r, os_nxt;
  logic [CHW-1:0] oh_r, oh_nxt;
  logic [2:0]     ovl_r, ovl_nxt;
  logic           oz_r, oz_nxt;

  // memories
  logic           node_we;
  logic [NW-1:0]  node_wdata, node_rdata;
  logic [HW-1:0]  node_raddr;
  logic           head_we;
  logic [HW-1:0]  head_waddr, head_wdata, head_rdata;

  logic           hs_start, hs_done;
  logic [HW-1:0]  hs_bucket;

  node_t          rd_node;
  logic [HW-1:0]  rd_link;
  logic [LVW-1:0] lv_eff;
  logic           cur_written, br_bit;
  logic [EVW-1:0] take_e;
  logic [CHW-1:0] take_c;
  logic [TCW-1:0] cfg_sat;
  logic           in_acc, out_acc, cfg_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cfg_acc = cfg_valid && cfg_ready;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;  // writes must come only while idle; the block itself does not enforce it

  assign rd_node = node_rdata[$bits(node_t)-1:0];
  assign rd_link = node_rdata[NW-1:$bits(node_t)];

  // Handles in [terminal_count, next_free) hold a node; anything else reads level 0.
  assign cur_written = (cur_r >= XW'(tc_r)) && (cur_r < XW'(nfree_r));
  assign lv_eff      = cur_written ? rd_node.lv : '0;
  // Levels past the variable vector read as 0.
  assign br_bit = ((lv_eff <= LVW'(VBW - 1)) ? var_r[lv_eff] : 1'b0) ^ inv_r;
  assign take_e = br_bit ? rd_node.e1 : rd_node.e0;
  assign take_c = br_bit ? rd_node.c1 : rd_node.c0;

  always_comb begin
    if (cfg_data < TERM_MIN) begin
      cfg_sat = TERM_MIN;
    end else if (cfg_data > TERM_MAX) begin
      cfg_sat = TERM_MAX;
    end else begin
      cfg_sat = cfg_data;
    end
  end

  assign hs_start = in_acc && (in_func == FUNC_INSERT) && (in_node_level != '0);

  assign node_raddr = HW'(cur_r);
  assign node_wdata = {head_r, tup_r};
  assign node_we    = (state_r == S_INS) && (nfree_r < NFW'(NODE_COUNT));

  // Bucket heads: the clear pass and new-node links share the write port.
  assign head_we    = (state_r == S_CLEAR) || node_we;
  assign head_waddr = (state_r == S_CLEAR) ? clr_cnt_r : bkt_r;
  assign head_wdata = (state_r == S_CLEAR) ? '0 : HW'(nfree_r);

  evbdd_hash #(.NODE_COUNT(NODE_COUNT)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hs_start),
    .tup    (tup_nxt),
    .done   (hs_done),
    .bucket (hs_bucket)
  );

  evbdd_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (HW'(nfree_r)),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  evbdd_ram #(.WIDTH(HW), .DEPTH(NODE_COUNT)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (bkt_r),
    .rdata (head_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    tc_nxt      = tc_r;
    nfree_nxt   = nfree_r;
    clr_cnt_nxt = clr_cnt_r;
    tup_nxt     = tup_r;
    bkt_nxt     = bkt_r;
    head_nxt    = head_r;
    cur_nxt     = cur_r;
    var_nxt     = var_r;
    rootv_nxt   = rootv_r;
    inv_nxt     = inv_r;
    sum_nxt     = sum_r;
    steps_nxt   = steps_r;
    rs_nxt      = rs_r;
    rh_nxt      = rh_r;
    rv_nxt      = rv_r;
    rz_nxt      = rz_r;
    ov_nxt      = ov_r;
    os_nxt      = os_r;
    oh_nxt      = oh_r;
    ovl_nxt     = ovl_r;
    oz_nxt      = oz_r;

    if (out_acc) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + HW'(1);
        if (clr_cnt_r == HW'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          tup_nxt.lv = in_node_level;
          tup_nxt.c0 = in_low_child;
          tup_nxt.c1 = in_high_child;
          tup_nxt.e0 = edge_mod5(in_low_edge_value);
          tup_nxt.e1 = edge_mod5(in_high_edge_value);
          cur_nxt    = XW'(in_root_handle);
          var_nxt    = in_var_bits;
          rootv_nxt  = in_root_value;
          inv_nxt    = in_invert_decisions;
          sum_nxt    = '0;
          steps_nxt  = '0;
          rs_nxt     = ST_OK;
          rh_nxt     = '0;
          rv_nxt     = '0;
          rz_nxt     = 1'b0;
          if (in_func == FUNC_INSERT) begin
            if (in_node_level == '0) begin
              rs_nxt    = ST_ZERO_LVL;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_HASH;
            end
          end else if (XW'(in_root_handle) >= XW'(nfree_r)) begin
            rs_nxt    = ST_BAD_ROOT;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_ERD;
          end
        end
      end
      S_HASH: begin
        if (hs_done) begin
          bkt_nxt   = hs_bucket;
          state_nxt = S_HRD;
        end
      end
      S_HRD: begin
        state_nxt = S_HDAT;
      end
      S_HDAT: begin
        head_nxt  = head_rdata;
        cur_nxt   = XW'(head_rdata);
        state_nxt = (head_rdata == '0) ? S_INS : S_NRD;
      end
      S_NRD: begin
        state_nxt = S_NCMP;
      end
      S_NCMP: begin
        if (rd_node == tup_r) begin
          rh_nxt    = CHW'(cur_r);
          state_nxt = S_OUT;
        end else begin
          cur_nxt   = XW'(rd_link);
          state_nxt = (rd_link == '0) ? S_INS : S_NRD;
        end
      end
      S_INS: begin
        if (nfree_r >= NFW'(NODE_COUNT)) begin
          rs_nxt = ST_FULL;
        end else begin
          rh_nxt    = CHW'(nfree_r);
          nfree_nxt = nfree_r + NFW'(1);
        end
        state_nxt = S_OUT;
      end
      S_ERD: begin
        state_nxt = S_ECHK;
      end
      S_ECHK: begin
        if (lv_eff == '0) begin
          // terminal, or a handle holding no node
          if (cur_r == '0) begin
            rz_nxt = 1'b1;
          end else begin
            rv_nxt = mod5(9'(sum_r) + 9'(rootv_r));
          end
          state_nxt = S_OUT;
        end else if (steps_r == SW'(MAX_LEVELS)) begin
          rs_nxt    = ST_WALK_LONG;
          state_nxt = S_OUT;
        end else begin
          sum_nxt   = mod5(9'(sum_r) + 9'(take_e));
          cur_nxt   = XW'(take_c);
          steps_nxt = steps_r + SW'(1);
          state_nxt = S_ERD;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          os_nxt    = rs_r;
          oh_nxt    = rh_r;
          ovl_nxt   = rv_r;
          oz_nxt    = rz_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // New terminal count empties the store.
    if (cfg_acc) begin
      tc_nxt      = cfg_sat;
      nfree_nxt   = NFW'(cfg_sat);
      clr_cnt_nxt = '0;
      state_nxt   = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      tc_r      <= TERM_RESET;
      nfree_r   <= NFW'(TERM_RESET);
      clr_cnt_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tc_r      <= tc_nxt;
      nfree_r   <= nfree_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      ov_r      <= ov_nxt;
      tup_r     <= tup_nxt;
      bkt_r     <= bkt_nxt;
      head_r    <= head_nxt;
      cur_r     <= cur_nxt;
      var_r     <= var_nxt;
      rootv_r   <= rootv_nxt;
      inv_r     <= inv_nxt;
      sum_r     <= sum_nxt;
      steps_r   <= steps_nxt;
      rs_r      <= rs_nxt;
      rh_r      <= rh_nxt;
      rv_r      <= rv_nxt;
      rz_r      <= rz_nxt;
      os_r      <= os_nxt;
      oh_r      <= oh_nxt;
      ovl_r     <= ovl_nxt;
      oz_r      <= oz_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = os_r;
  assign out_result_handle = oh_r;
  assign out_result_value  = ovl_r;
  assign out_reached_zero  = oz_r;

  `include "edge_valued_bdd_node_store_core_macros.svh"

  // An accepted item keeps the input closed until its result is loaded.
  `EVB_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready, "input open right after accept")
  // A node is only written below the table end.
  `EVB_ASSERT_NOW(a_write_in_range, node_we, nfree_r < NFW'(NODE_COUNT), "node write past end")
  // The free pointer never drops below the terminals.
  `EVB_ASSERT_NOW(a_nfree_floor, 1'b1, nfree_r >= NFW'(tc_r), "free handle below terminals")
  // The walk never runs past the step limit.
  `EVB_ASSERT_NOW(a_steps_cap, state_r == S_ECHK, steps_r <= SW'(MAX_LEVELS), "walk overrun")

endmodule
